// ----- hdl/fbsr_pkg.sv -----
`default_nettype none

package fbsr_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int CRD_W       = 7;
    localparam int POS_W       = 12;
    localparam int EXT_W       = 14;
    localparam int COLOR_W     = 32;
    localparam int COUNT_W     = 13;
    localparam int CMD_W       = 2;
    localparam int R2_W        = 22;
    localparam int SQ_W        = 24;
    localparam int SUM_W       = 25;
    localparam int PROD_W      = 28;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 48;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CRD_W-1:0] CANVAS_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_FILL,
        CMD_RECT,
        CMD_CIRCLE,
        CMD_READ
    } cmd_t;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_BOX,
        JOB_DISC,
        JOB_READ
    } job_kind_t;

    typedef enum logic {
        REG_CANVAS_WIDTH,
        REG_CANVAS_HEIGHT
    } reg_index_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_WALK,
        BK_DRAIN,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        job_kind_t               kind;
        logic [CRD_W-1:0]        xl;
        logic [CRD_W-1:0]        xh;
        logic [CRD_W-1:0]        yl;
        logic [CRD_W-1:0]        yh;
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic [R2_W-1:0]         r2;
        logic [COLOR_W-1:0]      color;
    } job_t;

endpackage

`default_nettype wire

// ----- hdl/fbsr_front.sv -----
`default_nettype none

module fbsr_front
    import fbsr_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic [CRD_W-1:0]      canvas_w,
    input  logic [CRD_W-1:0]      canvas_h,
    output logic                  job_valid,
    output job_t                  job,
    input  logic                  job_ready
);

    logic signed [POS_W-1:0]  x_pos;
    logic signed [POS_W-1:0]  y_pos;
    logic signed [POS_W-1:0]  rect_width;
    logic signed [POS_W-1:0]  rect_height;
    logic signed [POS_W-1:0]  radius;
    logic [COLOR_W-1:0]       color;
    logic signed [EXT_W-1:0]  xp_e;
    logic signed [EXT_W-1:0]  yp_e;
    logic signed [EXT_W-1:0]  rw_e;
    logic signed [EXT_W-1:0]  rh_e;
    logic signed [EXT_W-1:0]  rad_e;
    logic signed [EXT_W-1:0]  wm1;
    logic signed [EXT_W-1:0]  hm1;
    logic signed [EXT_W-1:0]  x1;
    logic signed [EXT_W-1:0]  x2;
    logic signed [EXT_W-1:0]  y1;
    logic signed [EXT_W-1:0]  y2;
    logic signed [EXT_W-1:0]  xl;
    logic signed [EXT_W-1:0]  xh;
    logic signed [EXT_W-1:0]  yl;
    logic signed [EXT_W-1:0]  yh;
    logic signed [SQ_W-1:0]   rad_sq;
    job_kind_t                kind;
    logic                     degenerate;
    logic                     empty;

    assign x_pos       = s_tdata[11:0];
    assign y_pos       = s_tdata[23:12];
    assign rect_width  = s_tdata[35:24];
    assign rect_height = s_tdata[47:36];
    assign radius      = s_tdata[59:48];
    assign color       = s_tdata[91:60];

    assign xp_e  = EXT_W'(x_pos);
    assign yp_e  = EXT_W'(y_pos);
    assign rw_e  = EXT_W'(rect_width);
    assign rh_e  = EXT_W'(rect_height);
    assign rad_e = EXT_W'(radius);
    assign wm1   = $signed({7'b0, canvas_w}) - 14'sd1;
    assign hm1   = $signed({7'b0, canvas_h}) - 14'sd1;

    assign rad_sq = SQ_W'(radius) * SQ_W'(radius);

    always_comb
    begin
        x1         = '0;
        x2         = wm1;
        y1         = '0;
        y2         = hm1;
        kind       = JOB_BOX;
        degenerate = 1'b0;
        unique case (cmd_t'(s_tuser))
            CMD_FILL:
            begin
                x1   = '0;
                x2   = wm1;
                y1   = '0;
                y2   = hm1;
                kind = JOB_BOX;
            end
            CMD_RECT:
            begin
                x1   = xp_e;
                x2   = xp_e + rw_e;
                y1   = yp_e;
                y2   = yp_e + rh_e;
                kind = JOB_BOX;
            end
            CMD_CIRCLE:
            begin
                x1         = xp_e - rad_e;
                x2         = xp_e + rad_e;
                y1         = yp_e - rad_e;
                y2         = yp_e + rad_e;
                kind       = JOB_DISC;
                degenerate = (radius <= 12'sd0);
            end
            CMD_READ:
            begin
                x1   = xp_e;
                x2   = xp_e;
                y1   = yp_e;
                y2   = yp_e;
                kind = JOB_READ;
            end
            default:
            begin
                kind = JOB_NONE;
            end
        endcase
    end

    // clip the bounding box to the canvas
    assign xl    = (x1 < 14'sd0) ? 14'sd0 : x1;
    assign xh    = (x2 > wm1) ? wm1 : x2;
    assign yl    = (y1 < 14'sd0) ? 14'sd0 : y1;
    assign yh    = (y2 > hm1) ? hm1 : y2;
    assign empty = degenerate || (xl > xh) || (yl > yh);

    always_comb
    begin
        job.kind  = empty ? JOB_NONE : kind;
        job.xl    = xl[CRD_W-1:0];
        job.xh    = xh[CRD_W-1:0];
        job.yl    = yl[CRD_W-1:0];
        job.yh    = yh[CRD_W-1:0];
        job.cx    = x_pos;
        job.cy    = y_pos;
        job.r2    = rad_sq[R2_W-1:0];
        job.color = color;
    end

    assign job_valid = s_tvalid;
    assign s_tready  = job_ready;

endmodule

`default_nettype wire

// ----- hdl/fbsr_queue.sv -----
`default_nettype none

module fbsr_queue
    import fbsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fbsr_back.sv -----
`default_nettype none

module fbsr_back
    import fbsr_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CRD_W-1:0]      canvas_w,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  job_t                  q_job,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    back_state_t          state_reg;
    back_state_t          state_next;
    job_t                 job_reg;
    logic [CRD_W-1:0]     x_reg;
    logic [CRD_W-1:0]     x_next;
    logic [CRD_W-1:0]     y_reg;
    logic [CRD_W-1:0]     y_next;
    logic [ADDR_W-1:0]    base_reg;
    logic [ADDR_W-1:0]    base_next;
    logic [COUNT_W-1:0]   count_reg;
    logic                 p_valid_reg;
    logic [ADDR_W-1:0]    p_addr_reg;
    logic [SQ_W-1:0]      p_dx2_reg;
    logic [SQ_W-1:0]      p_dy2_reg;
    logic [COLOR_W-1:0]   rdata_reg;
    logic                 out_valid_reg;
    logic [COLOR_W-1:0]   out_pixel_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [COLOR_W-1:0]   mem [DEPTH];

    logic                 take_job;
    logic                 init_walk;
    logic                 emit;
    logic                 deliver;
    logic                 last_pixel;
    logic                 row_end;
    logic [2*CRD_W-1:0]   row_start;
    logic signed [EXT_W-1:0]  dx;
    logic signed [EXT_W-1:0]  dy;
    logic signed [PROD_W-1:0] dx_ext;
    logic signed [PROD_W-1:0] dy_ext;
    logic signed [PROD_W-1:0] dx_sq;
    logic signed [PROD_W-1:0] dy_sq;
    logic [SUM_W-1:0]     dist_sq;
    logic                 in_disc;
    logic                 write_en;

    assign row_end    = (x_reg == job_reg.xh);
    assign last_pixel = row_end && (y_reg == job_reg.yh);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD:
            begin
                state_next = (job_reg.kind == JOB_NONE) ? BK_DONE : BK_WALK;
            end
            BK_WALK:
            begin
                if (last_pixel)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ready   = 1'b0;
        init_walk = 1'b0;
        emit      = 1'b0;
        deliver   = 1'b0;
        unique case (state_reg)
            BK_IDLE:  q_ready   = 1'b1;
            BK_LOAD:  init_walk = 1'b1;
            BK_WALK:  emit      = 1'b1;
            BK_DRAIN: emit      = 1'b0;
            BK_DONE:  deliver   = !out_valid_reg || m_tready;
            default:  q_ready   = 1'b0;
        endcase
    end

    assign take_job  = q_valid && q_ready;
    assign row_start = job_reg.yl * canvas_w;

    // box walk, row by row
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        base_next = base_reg;
        if (init_walk)
        begin
            x_next    = job_reg.xl;
            y_next    = job_reg.yl;
            base_next = ADDR_W'(row_start);
        end
        else if (emit && !last_pixel)
        begin
            if (row_end)
            begin
                x_next    = job_reg.xl;
                y_next    = y_reg + 1'b1;
                base_next = base_reg + ADDR_W'(canvas_w);
            end
            else
            begin
                x_next = x_reg + 1'b1;
            end
        end
    end

    assign dx     = $signed({7'b0, x_reg}) - EXT_W'(job_reg.cx);
    assign dy     = $signed({7'b0, y_reg}) - EXT_W'(job_reg.cy);
    assign dx_ext = PROD_W'(dx);
    assign dy_ext = PROD_W'(dy);
    assign dx_sq  = dx_ext * dx_ext;
    assign dy_sq  = dy_ext * dy_ext;

    assign dist_sq  = {1'b0, p_dx2_reg} + {1'b0, p_dy2_reg};
    assign in_disc  = (job_reg.kind != JOB_DISC) || (dist_sq <= SUM_W'(job_reg.r2));
    assign write_en = p_valid_reg && in_disc && (job_reg.kind != JOB_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            base_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= emit;
            x_reg       <= x_next;
            y_reg       <= y_next;
            base_reg    <= base_next;
            if (init_walk)
            begin
                count_reg <= '0;
            end
            else if (write_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_job)
        begin
            job_reg <= q_job;
        end
        if (emit)
        begin
            p_addr_reg <= base_reg + ADDR_W'(x_reg);
            p_dx2_reg  <= dx_sq[SQ_W-1:0];
            p_dy2_reg  <= dy_sq[SQ_W-1:0];
        end
        if (deliver)
        begin
            out_pixel_reg <= (job_reg.kind == JOB_READ) ? rdata_reg : '0;
            out_count_reg <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mem[p_addr_reg] <= job_reg.color;
        end
        rdata_reg <= mem[p_addr_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b0, out_count_reg, out_pixel_reg};

endmodule

`default_nettype wire

// ----- hdl/framebuffer_shape_raster.sv -----
`default_nettype none

// channel   dir   handshake                    payload
// s_*       in    s_tvalid / s_tready          s_tdata shape and color, s_tuser command
// m_*       out   m_tvalid / m_tready          m_tdata pixel value and pixel count
// apb       in    psel, penable, pready        paddr, pwdata, prdata canvas size
//
// a drawing item walks every pixel of its clipped bounding box in the back end,
// writing the frame memory at each pixel that it covers, all 4096 for a full 64 by 64 fill
// a read walks its one pixel; a fully clipped shape or an off-canvas read skips the walk
// a two-entry queue lets the next items be accepted while one is drawn
// reset clears control only; the frame memory holds garbage until drawn
// a stalled output holds its result and stops the back end after the next item

module framebuffer_shape_raster
    import fbsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // x_pos[11:0], y_pos[23:12], rect_width[35:24], rect_height[47:36],
    // radius[59:48], color[91:60], zero [95:92]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_value[31:0], pixels_written[44:32], zero [47:45]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [10:0] MAX_W_L = 11'(MAX_WIDTH);
    localparam logic [10:0] MAX_H_L = 11'(MAX_HEIGHT);

    logic [CRD_W-1:0] canvas_width_reg;
    logic [CRD_W-1:0] canvas_height_reg;
    logic [CRD_W-1:0] canvas_w;
    logic [CRD_W-1:0] canvas_h;
    logic             cfg_write;
    reg_index_t       cfg_index;
    logic             front_valid;
    logic             front_ready;
    job_t             front_job;
    logic             back_valid;
    logic             back_ready;
    job_t             back_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= CANVAS_RESET;
            canvas_height_reg <= CANVAS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CANVAS_WIDTH:  canvas_width_reg  <= pwdata[CRD_W-1:0];
                REG_CANVAS_HEIGHT: canvas_height_reg <= pwdata[CRD_W-1:0];
                default:           canvas_width_reg  <= canvas_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_CANVAS_WIDTH:  prdata = {25'b0, canvas_width_reg};
            REG_CANVAS_HEIGHT: prdata = {25'b0, canvas_height_reg};
            default:           prdata = '0;
        endcase
    end

    // canvas size saturates at the memory geometry
    assign canvas_w = ({4'b0, canvas_width_reg} > MAX_W_L) ? MAX_W_L[CRD_W-1:0]
                                                          : canvas_width_reg;
    assign canvas_h = ({4'b0, canvas_height_reg} > MAX_H_L) ? MAX_H_L[CRD_W-1:0]
                                                           : canvas_height_reg;

    fbsr_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .canvas_w  (canvas_w),
        .canvas_h  (canvas_h),
        .job_valid (front_valid),
        .job       (front_job),
        .job_ready (front_ready)
    );

    fbsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_job   (back_job)
    );

    fbsr_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .canvas_w (canvas_w),
        .q_valid  (back_valid),
        .q_ready  (back_ready),
        .q_job    (back_job),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- hdl/fbsr_checker.sv -----
`default_nettype none

module fbsr_checker
    import fbsr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // only a read returns a pixel, and a read writes nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[31:0] != 32'd0) |-> (m_tdata[44:32] == 13'd0))
        else $error("pixel value and pixel count both nonzero");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:45] == 3'd0))
        else $error("padding bits set");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result right out of reset");

endmodule

bind framebuffer_shape_raster fbsr_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
    import fbsr_pkg::*;
;

    localparam int MAX_W          = 64;
    localparam int MAX_H          = 64;
    localparam int FRAME_WORDS    = MAX_W * MAX_H;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 14;

    class raster_scoreboard;
        logic [COLOR_W-1:0] frame [FRAME_WORDS];
        int                 canvas_w;
        int                 canvas_h;
        logic [COLOR_W-1:0] exp_value_q [$];
        logic [COUNT_W-1:0] exp_count_q [$];
        int                 mismatches;
        int                 checked;
        int                 per_cmd [4];
        longint             pixels_total;

        function new();
            canvas_w     = MAX_W;
            canvas_h     = MAX_H;
            mismatches   = 0;
            checked      = 0;
            pixels_total = 0;
            foreach (per_cmd[i])
                per_cmd[i] = 0;
        endfunction

        function void set_canvas(reg_index_t idx, logic [PDATA_W-1:0] value);
            if (idx == REG_CANVAS_WIDTH)
                canvas_w = int'(value[CRD_W-1:0]);
            else
                canvas_h = int'(value[CRD_W-1:0]);
        endfunction

        function int eff_w();
            return canvas_w > MAX_W ? MAX_W : canvas_w;
        endfunction

        function int eff_h();
            return canvas_h > MAX_H ? MAX_H : canvas_h;
        endfunction

        // walk the clipped box, writing only points inside the disc when asked
        function int draw_box(int x1, int y1, int x2, int y2, bit disc,
                              int cx, int cy, int r, logic [COLOR_W-1:0] color);
            int     w;
            int     xl;
            int     xh;
            int     yl;
            int     yh;
            int     n;
            longint dx;
            longint dy;
            longint r2;
            w  = eff_w();
            xl = x1 > 0 ? x1 : 0;
            xh = x2 < w - 1 ? x2 : w - 1;
            yl = y1 > 0 ? y1 : 0;
            yh = y2 < eff_h() - 1 ? y2 : eff_h() - 1;
            r2 = longint'(r) * longint'(r);
            n  = 0;
            for (int y = yl; y <= yh; y++)
            begin
                for (int x = xl; x <= xh; x++)
                begin
                    dx = longint'(x - cx);
                    dy = longint'(y - cy);
                    if (!disc || dx * dx + dy * dy <= r2)
                    begin
                        frame[(y * w + x) % FRAME_WORDS] = color;
                        n++;
                    end
                end
            end
            return n;
        endfunction

        function void note_command(cmd_t cmd, int xp, int yp, int rw, int rh, int rad,
                                   logic [COLOR_W-1:0] color);
            logic [COLOR_W-1:0] value;
            int                 count;
            int                 w;
            int                 h;
            value = '0;
            count = 0;
            w     = eff_w();
            h     = eff_h();
            case (cmd)
                CMD_FILL:
                    count = draw_box(0, 0, MAX_W, MAX_H, 1'b0, 0, 0, 0, color);
                CMD_RECT:
                    count = draw_box(xp, yp, xp + rw, yp + rh, 1'b0, 0, 0, 0, color);
                CMD_CIRCLE:
                begin
                    if (rad > 0)
                        count = draw_box(xp - rad, yp - rad, xp + rad, yp + rad, 1'b1,
                                         xp, yp, rad, color);
                end
                default:
                begin
                    if (xp >= 0 && xp < w && yp >= 0 && yp < h)
                        value = frame[(yp * w + xp) % FRAME_WORDS];
                end
            endcase
            per_cmd[int'(cmd)]++;
            pixels_total += count;
            exp_value_q.push_back(value);
            exp_count_q.push_back(COUNT_W'(count));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            logic [COLOR_W-1:0] exp_value;
            logic [COUNT_W-1:0] exp_count;
            checked++;
            if (exp_count_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %h arrived with nothing pending", checked, data);
                return;
            end
            exp_value = exp_value_q.pop_front();
            exp_count = exp_count_q.pop_front();
            if (data[COLOR_W-1:0] !== exp_value || data[COLOR_W +: COUNT_W] !== exp_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: pixel_value exp %h got %h, pixels_written exp %0d got %0d",
                             checked, exp_value, data[COLOR_W-1:0],
                             exp_count, data[COLOR_W +: COUNT_W]);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // x_pos, y_pos, rect_width, rect_height, radius, color, zero pad
    logic [IN_DATA_W-1:0]  s_tdata;
    // cmd
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // pixel_value, pixels_written, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    raster_scoreboard sb;
    bit               tx_gaps = 1'b1;
    bit               rx_gaps = 1'b1;
    int               hold_cycles = 0;
    int               phase_w [PHASES] = '{1, 64, 1, 127, 0, 9, 13, 64};
    int               phase_h [PHASES] = '{1, 1, 64, 127, 7, 0, 9, 64};

    framebuffer_shape_raster u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int rand12();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    // mostly around the canvas, sometimes anywhere in the field range
    function automatic int near_pos(int span);
        if ($urandom_range(0, 99) < 80)
            return int'($urandom_range(0, span + 15)) - 8;
        return rand12();
    endfunction

    function automatic int pick_extent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(0, 12);
        if (r < 75)
            return -int'($urandom_range(1, 4));
        return rand12();
    endfunction

    function automatic int pick_radius();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(1, 12);
        if (r < 77)
            return -int'($urandom_range(0, 3));
        return rand12();
    endfunction

    // output side: random stalls plus the long hold-off on request
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else if (stall > 0)
            begin
                m_tready = 1'b0;
                stall--;
            end
            else
            begin
                m_tready = 1'b1;
                stall    = rx_gaps ? pick_gap() : 0;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_item(cmd_t cmd, int xp, int yp, int rw, int rh, int rad,
                             logic [COLOR_W-1:0] color);
        logic signed [POS_W-1:0] x12;
        logic signed [POS_W-1:0] y12;
        logic signed [POS_W-1:0] w12;
        logic signed [POS_W-1:0] h12;
        logic signed [POS_W-1:0] r12;
        int                      gap;
        x12 = POS_W'(xp);
        y12 = POS_W'(yp);
        w12 = POS_W'(rw);
        h12 = POS_W'(rh);
        r12 = POS_W'(rad);
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {{(IN_DATA_W - COLOR_W - 5 * POS_W){1'b0}}, color, r12, h12, w12, y12, x12};
        s_tuser  = cmd;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_command(cmd, x12, y12, w12, h12, r12, color);
        @(negedge clk);
    endtask

    task automatic send_random_item();
        int w;
        int h;
        int r;
        w = sb.eff_w();
        h = sb.eff_h();
        r = $urandom_range(0, 99);
        if (r < 10)
            send_item(CMD_FILL, rand12(), rand12(), rand12(), rand12(), rand12(), $urandom());
        else if (r < 45)
            send_item(CMD_RECT, near_pos(w), near_pos(h), pick_extent(), pick_extent(),
                      rand12(), $urandom());
        else if (r < 72)
            send_item(CMD_CIRCLE, near_pos(w), near_pos(h), rand12(), rand12(),
                      pick_radius(), $urandom());
        else
            send_item(CMD_READ, near_pos(w), near_pos(h), rand12(), rand12(), rand12(),
                      $urandom());
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.exp_count_q.size() != 0)
            @(posedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic apb_write(reg_index_t idx, logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(idx) << 2;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_canvas(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial
    begin
        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // full fills first so every pixel is defined before any read
        send_item(CMD_FILL, 0, 0, 0, 0, 0, 32'h0000_0000);
        send_item(CMD_FILL, -2048, 2047, -2048, 2047, -2048, 32'hFFFF_FFFF);
        send_item(CMD_RECT, -2048, -2048, 2047, 2047, 0, 32'h1234_5678);
        send_item(CMD_RECT, -5, -5, 2047, 2047, 0, 32'hAAAA_5555);
        send_item(CMD_RECT, 0, 0, 0, 0, 0, 32'h0000_0001);
        send_item(CMD_RECT, 2047, 2047, 0, 0, 0, 32'h8000_0000);
        send_item(CMD_RECT, 10, 20, -1, 5, 0, 32'hDEAD_BEEF);
        send_item(CMD_RECT, 10, 20, 5, -2048, 0, 32'hDEAD_BEEF);
        send_item(CMD_RECT, 60, 3, 0, 10, 0, 32'h0F0F_0F0F);
        send_item(CMD_RECT, 5, 63, 2047, 0, 0, 32'h5555_AAAA);
        send_item(CMD_CIRCLE, 32, 32, 0, 0, 0, 32'hCAFE_F00D);
        send_item(CMD_CIRCLE, 32, 32, 0, 0, -2048, 32'hCAFE_F00D);
        send_item(CMD_CIRCLE, 0, 0, 0, 0, 1, 32'h0000_FFFF);
        send_item(CMD_CIRCLE, 0, 0, 0, 0, 2047, 32'h3C3C_3C3C);
        send_item(CMD_CIRCLE, -2048, 2047, 0, 0, 2047, 32'h7777_7777);
        send_item(CMD_CIRCLE, 63, -3, 0, 0, 7, 32'hFFFF_0000);
        send_item(CMD_CIRCLE, 2047, -2048, 0, 0, 5, 32'h0101_0101);
        send_item(CMD_READ, 0, 0, 0, 0, 0, 32'h0);
        send_item(CMD_READ, 63, 63, 0, 0, 0, 32'h0);
        send_item(CMD_READ, 64, 0, 0, 0, 0, 32'h0);
        send_item(CMD_READ, -1, 5, 0, 0, 0, 32'h0);
        send_item(CMD_READ, 2047, -2048, 0, 0, 0, 32'h0);
        send_item(CMD_READ, 5, 63, 0, 0, 0, 32'h0);
        send_item(CMD_READ, 1, 0, 0, 0, 0, 32'h0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            tx_gaps = (p != 3);
            rx_gaps = (p != 3);
            apb_write(REG_CANVAS_WIDTH, phase_w[p]);
            apb_write(REG_CANVAS_HEIGHT, phase_h[p]);
            if (p == 6)
            begin
                // output held off while small items keep coming
                tx_gaps     = 1'b0;
                hold_cycles = HOLD_CYCLES;
                for (int i = 0; i < 10; i++)
                begin
                    if (i % 2 == 0)
                        send_item(CMD_READ, i, i % 5, 0, 0, 0, $urandom());
                    else
                        send_item(CMD_RECT, i, i % 5, 1, 1, 0, $urandom());
                end
                tx_gaps = 1'b1;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 1 && i == 7)
                    wait_idle();
                send_random_item();
            end
        end
        wait_idle();

        $display("%0d items: %0d fills, %0d rectangles, %0d circles, %0d reads; %0d results checked",
                 sb.per_cmd[0] + sb.per_cmd[1] + sb.per_cmd[2] + sb.per_cmd[3],
                 sb.per_cmd[0], sb.per_cmd[1], sb.per_cmd[2], sb.per_cmd[3], sb.checked);
        $display("canvas swept through empty, 1x1, single row and column, oversized; %0d pixels drawn",
                 sb.pixels_total);
        if (sb.mismatches == 0 && sb.exp_count_q.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.exp_count_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/fbsr_pkg.sv
hdl/fbsr_front.sv
hdl/fbsr_queue.sv
hdl/fbsr_back.sv
hdl/framebuffer_shape_raster.sv
hdl/fbsr_checker.sv
tb/tb_top.sv
